### rtl/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg: shared definitions for the differential drive odometry core
// Widths, CORDIC constants, multiplier operand codes and the command word
// that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package ddo_pkg;

  // CORDIC iteration count; the arctangent table caps it.
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned AngTableLen = 24;
  localparam int unsigned CordicIters =
      (CordicSteps > AngTableLen) ? AngTableLen : CordicSteps;
  localparam int unsigned IterW = $clog2(AngTableLen);

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 20;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  localparam cfg_idx_t RegSpeedScale    = 2'd0;
  localparam cfg_idx_t RegAnglePerMeter = 2'd1;

  // Datapath widths
  localparam int unsigned CordW = 34;
  localparam int unsigned MulW  = 34;
  localparam int unsigned ProdW = 2 * MulW;

  // Start vector length in Q1.30, the CORDIC gain folded in
  localparam logic signed [CordW-1:0] CordicGain = 34'sd652032874;

  // Arctangent of 2^-i in units of a 32-bit binary turn
  localparam logic [31:0] AtanTurn [AngTableLen] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Operand pairs for the shared multiplier
  typedef enum logic [2:0] {
    MulLeftSpeed  = 3'd0,
    MulRightSpeed = 3'd1,
    MulTime       = 3'd2,
    MulHeading    = 3'd3,
    MulCos        = 3'd4,
    MulSin        = 3'd5
  } mul_op_e;

  typedef struct packed {
    logic             load_in;
    mul_op_e          mul_op;
    logic             cap_dl;
    logic             cap_dr;
    logic             upd_heading;
    logic             cordic_init;
    logic             cordic_step;
    logic [IterW-1:0] iter;
    logic             cordic_fix;
    logic             upd_x;
    logic             upd_y;
    logic             load_out;
  } dp_cmd_t;

endpackage

### rtl/ddo_ctrl.sv
// ----------------------------------------------------------------------------
// ddo_ctrl: sequencer for the odometry update
// Walks one transaction through the multiply schedule, the CORDIC
// iterations and the position update, and owns both handshakes.
// ----------------------------------------------------------------------------
module ddo_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output ddo_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [14:0] {
    StIdle = 15'h0001,
    StLs   = 15'h0002,
    StLt   = 15'h0004,
    StRs   = 15'h0008,
    StRt   = 15'h0010,
    StDr   = 15'h0020,
    StHd   = 15'h0040,
    StHu   = 15'h0080,
    StCi   = 15'h0100,
    StCr   = 15'h0200,
    StCf   = 15'h0400,
    StMx   = 15'h0800,
    StMy   = 15'h1000,
    StXy   = 15'h2000,
    StDone = 15'h4000
  } state_e;

  state_e                    state_q, state_d;
  logic [ddo_pkg::IterW-1:0] iter_q, iter_d;
  logic                      out_valid_q, out_valid_d;
  logic                      iter_last;

  assign iter_last   = (iter_q == ddo_pkg::IterW'(ddo_pkg::CordicIters - 1));
  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d       = state_q;
    iter_d        = iter_q;
    cmd_o         = '0;
    cmd_o.mul_op  = ddo_pkg::MulLeftSpeed;
    cmd_o.iter    = iter_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = StLs;
        end
      end
      StLs: begin
        cmd_o.mul_op = ddo_pkg::MulLeftSpeed;
        state_d      = StLt;
      end
      StLt: begin
        cmd_o.mul_op = ddo_pkg::MulTime;
        state_d      = StRs;
      end
      StRs: begin
        cmd_o.cap_dl = 1'b1;
        cmd_o.mul_op = ddo_pkg::MulRightSpeed;
        state_d      = StRt;
      end
      StRt: begin
        cmd_o.mul_op = ddo_pkg::MulTime;
        state_d      = StDr;
      end
      StDr: begin
        cmd_o.cap_dr = 1'b1;
        state_d      = StHd;
      end
      StHd: begin
        cmd_o.mul_op = ddo_pkg::MulHeading;
        state_d      = StHu;
      end
      StHu: begin
        cmd_o.upd_heading = 1'b1;
        state_d           = StCi;
      end
      StCi: begin
        cmd_o.cordic_init = 1'b1;
        iter_d            = '0;
        state_d           = StCr;
      end
      StCr: begin
        cmd_o.cordic_step = 1'b1;
        if (iter_last) begin
          state_d = StCf;
        end else begin
          iter_d = iter_q + 1'b1;
        end
      end
      StCf: begin
        cmd_o.cordic_fix = 1'b1;
        state_d          = StMx;
      end
      StMx: begin
        cmd_o.mul_op = ddo_pkg::MulCos;
        state_d      = StMy;
      end
      StMy: begin
        cmd_o.mul_op = ddo_pkg::MulSin;
        cmd_o.upd_x  = 1'b1;
        state_d      = StXy;
      end
      StXy: begin
        cmd_o.upd_y = 1'b1;
        state_d     = StDone;
      end
      StDone: begin
        // hold until the output register is free or drains this cycle
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### rtl/ddo_datapath.sv
// ----------------------------------------------------------------------------
// ddo_datapath: arithmetic for the odometry update
// Configuration registers, one shared registered multiplier, an iterative
// CORDIC rotator, the pose state and the output register.
// ----------------------------------------------------------------------------
module ddo_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ddo_pkg::dp_cmd_t             cmd_i,
  input  logic                         cfg_we_i,
  input  ddo_pkg::cfg_idx_t            cfg_idx_i,
  input  logic [ddo_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic signed [15:0]           left_ticks_i,
  input  logic signed [15:0]           right_ticks_i,
  input  logic [15:0]                  elapsed_time_i,
  output logic signed [31:0]           pos_x_o,
  output logic signed [31:0]           pos_y_o,
  output logic [15:0]                  heading_o
);

  localparam int unsigned MulW  = ddo_pkg::MulW;
  localparam int unsigned ProdW = ddo_pkg::ProdW;
  localparam int unsigned CordW = ddo_pkg::CordW;

  // configuration
  logic [15:0] speed_q;
  logic [19:0] apm_q;

  // latched transaction
  logic signed [15:0] left_q, right_q;
  logic [15:0]        time_q;

  // multiplier
  logic signed [MulW-1:0]  mul_a, mul_b;
  logic signed [ProdW-1:0] prod_d, prod_q;

  // wheel distances
  logic signed [31:0] dl_q, dr, mean_q;
  logic signed [32:0] diff_q, sum_lr;

  // pose
  logic [15:0]        heading_q;
  logic signed [31:0] x_q, y_q;
  logic signed [37:0] dpos;
  logic signed [38:0] x_sum, y_sum;

  // CORDIC
  logic signed [CordW-1:0] cx_q, cy_q, cz_q;
  logic signed [CordW-1:0] xs, ys, atan_v;
  logic                    flip;
  logic                    flip_q;
  logic [31:0]             ang;

  // output register
  logic signed [31:0] out_x_q, out_y_q;
  logic [15:0]        out_h_q;

  function automatic logic signed [31:0] sat32(input logic signed [38:0] v);
    logic signed [31:0] r;
    if (v > 39'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -39'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= '0;
      apm_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ddo_pkg::RegSpeedScale:    speed_q <= cfg_wdata_i[15:0];
        ddo_pkg::RegAnglePerMeter: apm_q   <= cfg_wdata_i[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.mul_op)
      ddo_pkg::MulLeftSpeed: begin
        mul_a = MulW'(left_q);
        mul_b = {{(MulW-16){1'b0}}, speed_q};
      end
      ddo_pkg::MulRightSpeed: begin
        mul_a = MulW'(right_q);
        mul_b = {{(MulW-16){1'b0}}, speed_q};
      end
      ddo_pkg::MulTime: begin
        mul_a = MulW'(signed'(prod_q[31:0]));
        mul_b = {{(MulW-16){1'b0}}, time_q};
      end
      ddo_pkg::MulHeading: begin
        mul_a = MulW'(diff_q);
        mul_b = {{(MulW-20){1'b0}}, apm_q};
      end
      ddo_pkg::MulCos: begin
        mul_a = MulW'(mean_q);
        mul_b = cx_q;
      end
      ddo_pkg::MulSin: begin
        mul_a = MulW'(mean_q);
        mul_b = cy_q;
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // floor shift by 16 of a value known to fit 48 bits
  assign dr     = signed'(prod_q[47:16]);
  assign sum_lr = 33'(dl_q) + 33'(dr);

  // move angles of the left half plane by half a turn
  assign flip = heading_q[15] ^ heading_q[14];
  assign ang  = {heading_q[15] ^ flip, heading_q[14:0], 16'h0000};

  assign xs     = cx_q >>> cmd_i.iter;
  assign ys     = cy_q >>> cmd_i.iter;
  assign atan_v = {{(CordW-32){1'b0}}, ddo_pkg::AtanTurn[cmd_i.iter]};

  assign dpos  = signed'(prod_q[ProdW-1:30]);
  assign x_sum = 39'(x_q) + 39'(dpos);
  assign y_sum = 39'(y_q) + 39'(dpos);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.load_in) begin
      left_q  <= left_ticks_i;
      right_q <= right_ticks_i;
      time_q  <= elapsed_time_i;
    end
    if (cmd_i.cap_dl) begin
      dl_q <= signed'(prod_q[47:16]);
    end
    if (cmd_i.cap_dr) begin
      diff_q <= 33'(dr) - 33'(dl_q);
      mean_q <= signed'(sum_lr[32:1]);
    end
    if (cmd_i.cordic_init) begin
      cx_q   <= ddo_pkg::CordicGain;
      cy_q   <= '0;
      cz_q   <= CordW'(signed'(ang));
      flip_q <= flip;
    end else if (cmd_i.cordic_step) begin
      if (!cz_q[CordW-1]) begin
        cx_q <= cx_q - ys;
        cy_q <= cy_q + xs;
        cz_q <= cz_q - atan_v;
      end else begin
        cx_q <= cx_q + ys;
        cy_q <= cy_q - xs;
        cz_q <= cz_q + atan_v;
      end
    end else if (cmd_i.cordic_fix && flip_q) begin
      cx_q <= -cx_q;
      cy_q <= -cy_q;
    end
    if (cmd_i.load_out) begin
      out_x_q <= x_q;
      out_y_q <= y_q;
      out_h_q <= heading_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heading_q <= '0;
      x_q       <= '0;
      y_q       <= '0;
    end else begin
      if (cmd_i.upd_heading) begin
        // only the low word of the heading step survives the wrap
        heading_q <= heading_q + prod_q[31:16];
      end
      if (cmd_i.upd_x) begin
        x_q <= sat32(x_sum);
      end
      if (cmd_i.upd_y) begin
        y_q <= sat32(y_sum);
      end
    end
  end

  assign pos_x_o   = out_x_q;
  assign pos_y_o   = out_y_q;
  assign heading_o = out_h_q;

endmodule

### rtl/differential_drive_odometry_core.sv
// ----------------------------------------------------------------------------
// differential_drive_odometry_core: dead-reckoning pose update
// Integrates wheel tick counts into a saturating Q16.16 position and a
// wrapping 16-bit heading, with sin and cos from an iterative CORDIC.
//
//   Channel  Handshake                 Payload
//   -------  ------------------------  --------------------------------------
//   in       in_valid_i / in_stall_o   left_ticks_i, right_ticks_i,
//                                      elapsed_time_i
//   out      out_valid_o / out_stall_i pos_x_o, pos_y_o, heading_o
//   cfg      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// Each transaction passes through the accept state, shared-multiplier work for
// wheel distances and heading, one CORDIC iteration per cycle, then the
// position update and hand-off; in_stall_o stays high until the sequencer is
// idle again.
// A finished result sits in an output register, so the next transaction is
// taken while it waits; the sequencer only holds in its last state if that
// register is still full and stalled.
// Reset clears the pose and both configuration registers.
// ----------------------------------------------------------------------------
module differential_drive_odometry_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  ddo_pkg::cfg_idx_t            cfg_idx_i,
  input  logic [ddo_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [15:0]           left_ticks_i,
  input  logic signed [15:0]           right_ticks_i,
  input  logic [15:0]                  elapsed_time_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [31:0]           pos_x_o,
  output logic signed [31:0]           pos_y_o,
  output logic [15:0]                  heading_o
);

  ddo_pkg::dp_cmd_t cmd;

  ddo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  ddo_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .left_ticks_i   (left_ticks_i),
    .right_ticks_i  (right_ticks_i),
    .elapsed_time_i (elapsed_time_i),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .heading_o      (heading_o)
  );

endmodule

### sim/differential_drive_odometry_core_test.sv
// ----------------------------------------------------------------------------
// differential_drive_odometry_core_test: self-checking bench for the odometry core
// Drives wheel tick transactions with random gaps, stalls the pose output at
// random and for one long stretch, and predicts every pose in fixed point
// (wheel distances, wrapping heading, CORDIC sin/cos, saturating x and y).
// Each accepted pose is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module differential_drive_odometry_core_test;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned MAX_PRINTS     = 200;
  localparam int unsigned CORDIC_ITERS   = ddo_pkg::CordicIters;
  localparam longint      CORDIC_GAIN    = 64'sd652032874;
  localparam int unsigned ITEMS_PER_CFG  = 64;
  localparam int unsigned PHASE_ITEMS    = 320;

  // Indexes past the last register; writes there must be dropped
  localparam ddo_pkg::cfg_idx_t RegSpare2 = 2'd2;
  localparam ddo_pkg::cfg_idx_t RegSpare3 = 2'd3;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [15:0]        hdg;
  } pose_t;

  logic                         clk_i          = 1'b0;
  logic                         rst_ni         = 1'b0;
  logic                         cfg_we_i       = 1'b0;
  ddo_pkg::cfg_idx_t            cfg_idx_i      = ddo_pkg::RegSpeedScale;
  logic [ddo_pkg::CfgDataW-1:0] cfg_wdata_i    = '0;
  logic                         in_valid_i     = 1'b0;
  logic                         in_stall_o;
  logic signed [15:0]           left_ticks_i   = '0;
  logic signed [15:0]           right_ticks_i  = '0;
  logic [15:0]                  elapsed_time_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i    = 1'b0;
  logic signed [31:0]           pos_x_o;
  logic signed [31:0]           pos_y_o;
  logic [15:0]                  heading_o;

  // Pose and register copies of the predictor
  logic [15:0]           speed_scale_q     = '0;
  logic [19:0]           angle_per_meter_q = '0;
  logic signed [31:0]    pos_x_q           = '0;
  logic signed [31:0]    pos_y_q           = '0;
  logic [15:0]           heading_q         = '0;
  pose_t                 expected_poses[$];

  int unsigned           mismatch_count = 0;
  int unsigned           send_idle_pct  = 0;
  int unsigned           stall_pct      = 0;
  int unsigned           hold_req_count = 0;
  int unsigned           hold_ack_count = 0;
  int unsigned           hold_left      = 0;
  int unsigned           quiet_cycles   = 0;

  longint atan_turn [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  differential_drive_odometry_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .left_ticks_i   (left_ticks_i),
    .right_ticks_i  (right_ticks_i),
    .elapsed_time_i (elapsed_time_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .heading_o      (heading_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  task automatic cordic_sin_cos(input logic [15:0] ang, output longint c, output longint s);
    logic [31:0] turn;
    logic [31:0] probe;
    logic        flip;
    int          za;
    int          i;
    longint      x;
    longint      y;
    longint      z;
    longint      xs;
    longint      ys;
    turn  = {ang, 16'h0000};
    probe = turn + 32'h4000_0000;
    flip  = probe[31];
    // Fold the left half plane onto the right one, negate at the end
    if (flip) turn = turn - 32'h8000_0000;
    za = turn;
    z  = za;
    x  = CORDIC_GAIN;
    y  = 0;
    for (i = 0; i < CORDIC_ITERS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - atan_turn[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + atan_turn[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = x;
    s = y;
  endtask

  task automatic advance_pose(input logic signed [15:0] lt, input logic signed [15:0] rt,
                              input logic [15:0] et);
    longint l_ticks;
    longint r_ticks;
    longint dur;
    longint scale;
    longint ang_gain;
    longint dl;
    longint dr;
    longint mean;
    longint dh;
    longint cos_v;
    longint sin_v;
    pose_t  p;
    l_ticks  = lt;
    r_ticks  = rt;
    dur      = et;
    scale    = speed_scale_q;
    ang_gain = angle_per_meter_q;
    dl   = (l_ticks * scale * dur) >>> 16;
    dr   = (r_ticks * scale * dur) >>> 16;
    mean = (dl + dr) >>> 1;
    dh   = ((dr - dl) * ang_gain) >>> 16;
    heading_q = heading_q + dh[15:0];
    cordic_sin_cos(heading_q, cos_v, sin_v);
    pos_x_q = clamp32(longint'(pos_x_q) + ((mean * cos_v) >>> 30));
    pos_y_q = clamp32(longint'(pos_y_q) + ((mean * sin_v) >>> 30));
    p.x   = pos_x_q;
    p.y   = pos_y_q;
    p.hdg = heading_q;
    expected_poses.push_back(p);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatch_count < MAX_PRINTS)
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    mismatch_count++;
  endtask

  // Offer one transaction; valid stays high afterwards so back-to-back items never dip
  task automatic offer_wheel_ticks(input logic signed [15:0] lt, input logic signed [15:0] rt,
                                   input logic [15:0] et);
    int unsigned gap;
    gap = 0;
    while (gap < 200 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    left_ticks_i   <= lt;
    right_ticks_i  <= rt;
    elapsed_time_i <= et;
    in_valid_i     <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    advance_pose(lt, rt, et);
  endtask

  // Drop valid and hold off until every predicted pose has come back
  task automatic drain_poses();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_poses.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input ddo_pkg::cfg_idx_t idx,
                           input logic [ddo_pkg::CfgDataW-1:0] data);
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == ddo_pkg::RegSpeedScale) speed_scale_q = data[15:0];
    else if (idx == ddo_pkg::RegAnglePerMeter) angle_per_meter_q = data[19:0];
    @(posedge clk_i);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    stall_pct    <= recv_pct;
  endtask

  task automatic test_reset_pose();
    // Registers come out of reset at zero, so nothing moves
    set_idling(0, 0);
    offer_wheel_ticks(16'sh7FFF, -16'sh8000, 16'hFFFF);
    offer_wheel_ticks(-16'sh8000, 16'sh7FFF, 16'hFFFF);
    drain_poses();
  endtask

  task automatic test_register_decode();
    write_reg(RegSpare2, '1);
    write_reg(RegSpare3, '1);
    write_reg(ddo_pkg::RegSpeedScale, '1);
    write_reg(ddo_pkg::RegAnglePerMeter, '0);
    // Straight runs at full scale: clamp x high, then low
    offer_wheel_ticks(16'sh7FFF, 16'sh7FFF, 16'hFFFF);
    offer_wheel_ticks(16'sh7FFF, 16'sh7FFF, 16'hFFFF);
    offer_wheel_ticks(-16'sh8000, -16'sh8000, 16'hFFFF);
    offer_wheel_ticks(-16'sh8000, -16'sh8000, 16'hFFFF);
    offer_wheel_ticks(-16'sh8000, -16'sh8000, 16'hFFFF);
    offer_wheel_ticks(16'sh7FFF, -16'sh8000, 16'h0000);
    drain_poses();
  endtask

  task automatic test_heading_and_wrap();
    write_reg(ddo_pkg::RegAnglePerMeter, 20'd1);
    // Spin in place to roughly a quarter turn, then clamp y both ways
    offer_wheel_ticks(-16'sd8192, 16'sd8192, 16'hFFFF);
    offer_wheel_ticks(16'sh7FFF, 16'sh7FFF, 16'hFFFF);
    offer_wheel_ticks(16'sh7FFF, 16'sh7FFF, 16'hFFFF);
    offer_wheel_ticks(-16'sh8000, -16'sh8000, 16'hFFFF);
    offer_wheel_ticks(-16'sh8000, -16'sh8000, 16'hFFFF);
    offer_wheel_ticks(-16'sh8000, -16'sh8000, 16'hFFFF);
    drain_poses();
    write_reg(ddo_pkg::RegAnglePerMeter, 20'hFFFFF);
    // Opposite extremes push the heading far past a full turn
    offer_wheel_ticks(-16'sh8000, 16'sh7FFF, 16'hFFFF);
    offer_wheel_ticks(16'sh7FFF, -16'sh8000, 16'hFFFF);
    offer_wheel_ticks(-16'sh8000, 16'sh7FFF, 16'h8000);
    offer_wheel_ticks(16'sd1, 16'sd0, 16'h0001);
    offer_wheel_ticks(16'sd300, 16'sd310, 16'h4000);
    offer_wheel_ticks(-16'sd1, -16'sd1, 16'hFFFF);
    drain_poses();
  endtask

  task automatic test_output_backpressure();
    int n;
    write_reg(ddo_pkg::RegSpeedScale, 20'd40000);
    write_reg(ddo_pkg::RegAnglePerMeter, 20'd5000);
    set_idling(0, 0);
    hold_req_count <= hold_req_count + 1;
    for (n = 0; n < 12; n++)
      offer_wheel_ticks(16'($urandom_range(2000)), 16'($urandom_range(2000)),
                        16'($urandom()));
    drain_poses();
  endtask

  task automatic write_random_config(input bit extremes);
    logic [ddo_pkg::CfgDataW-1:0] sp;
    logic [ddo_pkg::CfgDataW-1:0] apm;
    if (extremes) begin
      sp  = 20'h0FFFF;
      apm = 20'hFFFFF;
    end else begin
      case ($urandom_range(3))
        0:       sp = $urandom_range(1) ? 20'h0FFFF : 20'h00000;
        1:       sp = 20'($urandom_range(4096));
        default: sp = 20'($urandom_range(65535));
      endcase
      case ($urandom_range(3))
        0:       apm = 20'hFFFFF;
        1:       apm = 20'($urandom_range(256));
        default: apm = 20'($urandom_range(1048575));
      endcase
    end
    write_reg(ddo_pkg::RegSpeedScale, sp);
    write_reg(ddo_pkg::RegAnglePerMeter, apm);
  endtask

  task automatic test_random_traffic();
    int          phase;
    int          n;
    logic signed [15:0] lt;
    logic signed [15:0] rt;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       set_idling(0, 0);
        1:       set_idling(78, 0);
        2:       set_idling(0, 78);
        default: set_idling(22, 22);
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % ITEMS_PER_CFG == 0) begin
          drain_poses();
          write_random_config(phase == 0 && n == 0);
        end
        case ($urandom_range(3))
          0: begin
            lt = 16'($urandom());
            rt = 16'($urandom());
          end
          3: begin
            lt = 16'($urandom_range(1200) - 600);
            rt = 16'(lt + $urandom_range(16) - 8);
          end
          default: begin
            lt = 16'($urandom_range(1200) - 600);
            rt = 16'($urandom_range(1200) - 600);
          end
        endcase
        offer_wheel_ticks(lt, rt, 16'($urandom()));
      end
      drain_poses();
    end
  endtask

  // Receiver: random stalls, plus one long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_req_count != hold_ack_count) begin
      hold_ack_count <= hold_req_count;
      hold_left      <= HOLD_CYCLES;
      out_stall_i    <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left      <= hold_left - 1;
      out_stall_i    <= 1'b1;
    end else begin
      out_stall_i    <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    pose_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_poses.size() == 0) begin
        report_mismatch("unexpected pose", pos_x_o, 0);
      end else begin
        want = expected_poses.pop_front();
        if (pos_x_o !== want.x) report_mismatch("pos_x", pos_x_o, want.x);
        if (pos_y_o !== want.y) report_mismatch("pos_y", pos_y_o, want.y);
        if (heading_o !== want.hdg) report_mismatch("heading", heading_o, want.hdg);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("differential_drive_odometry_core_test failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_pose();
    test_register_decode();
    test_heading_and_wrap();
    test_output_backpressure();
    test_random_traffic();
    drain_poses();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("differential_drive_odometry_core_test passed");
    end else begin
      $display("differential_drive_odometry_core_test failed");
    end
    $finish;
  end

endmodule
